FILE: hw/rtl/ftf_pkg.sv
// Shared types and constants for the five-tuple packet filter rule table.
// Used by ftf_cell and five_tuple_packet_filter_rule_table; no dependencies.
package ftf_pkg;

  // Operation codes carried by an input word.
  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_ADD      = 2'd1;
  localparam logic [1:0] OP_REMOVE   = 2'd2;

  // Status codes of a result word.
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // IP protocol numbers that classification looks at.
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // One rule, or the rule fields of a request.
  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [15:0] dst_port;
  } ftf_rule_t;

  // Request body that walks down the chain of rule cells.
  typedef struct packed {
    logic [1:0] op;
    logic       dir;
    ftf_rule_t  rule;
    logic       done;     // an earlier cell (or the entry stage) settled the request
    logic       verdict;  // drop, for classify
  } ftf_body_t;

  // A chain stage: valid flag plus body.
  typedef struct packed {
    logic      valid;
    ftf_body_t body;
  } ftf_word_t;

endpackage

FILE: hw/rtl/ftf_cell.sv
// One rule cell of the filter chain: holds the outbound and the inbound rule of one slot.
// Depends on ftf_pkg for the rule and chain word types.
module ftf_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ftf_pkg::ftf_word_t word_i,
  output ftf_pkg::ftf_word_t word_o
);

  // Rule storage, one entry per direction.
  logic [1:0]         rule_valid_q, rule_valid_d;
  ftf_pkg::ftf_rule_t rule_q [2];

  logic               valid_q;
  ftf_pkg::ftf_body_t body_q, body_d;

  logic               active;
  logic               dir;
  logic               cls_hit, add_hit, rem_hit;

  // An address field matches when it is zero or agrees under its own mask.
  function automatic logic addr_hit(logic [31:0] rule_addr, logic [31:0] mask,
                                    logic [31:0] pkt_addr);
    return (rule_addr == 32'd0) || (((rule_addr ^ pkt_addr) & mask) == 32'd0);
  endfunction

  // A stored rule matches a packet when every nonzero field agrees.
  function automatic logic rule_match(ftf_pkg::ftf_rule_t r, ftf_pkg::ftf_rule_t p);
    return ((r.protocol == 8'd0) || (r.protocol == p.protocol)) &&
           addr_hit(r.src_addr, r.src_mask, p.src_addr) &&
           ((r.src_port == 16'd0) || (r.src_port == p.src_port)) &&
           addr_hit(r.dst_addr, r.dst_mask, p.dst_addr) &&
           ((r.dst_port == 16'd0) || (r.dst_port == p.dst_port));
  endfunction

  // Decide what this cell does with the passing word.
  always_comb begin
    dir     = word_i.body.dir;
    active  = word_i.valid && !word_i.body.done;
    cls_hit = active && (word_i.body.op == ftf_pkg::OP_CLASSIFY) && rule_valid_q[dir] &&
              rule_match(rule_q[dir], word_i.body.rule);
    add_hit = active && (word_i.body.op == ftf_pkg::OP_ADD) && !rule_valid_q[dir];
    rem_hit = active && (word_i.body.op == ftf_pkg::OP_REMOVE) && rule_valid_q[dir] &&
              (rule_q[dir] == word_i.body.rule);

    body_d = word_i.body;
    if (cls_hit || add_hit || rem_hit) begin
      body_d.done = 1'b1;
    end
    if (cls_hit) begin
      body_d.verdict = 1'b1;
    end

    rule_valid_d = rule_valid_q;
    if (add_hit) begin
      rule_valid_d[dir] = 1'b1;
    end
    if (rem_hit) begin
      rule_valid_d[dir] = 1'b0;
    end
  end

  // Valid marks and the stage valid flag are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_valid_q <= 2'b00;
      valid_q      <= 1'b0;
    end else begin
      rule_valid_q <= rule_valid_d;
      valid_q      <= word_i.valid;
    end
  end

  // Rule fields and the forwarded body need no reset.
  always_ff @(posedge clk_i) begin
    body_q <= body_d;
    if (add_hit) begin
      rule_q[dir] <= word_i.body.rule;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.body  = body_q;

  // A settled request stays settled further down the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_i.valid && word_i.body.done) |=> word_o.body.done)
    else $error("settled request lost its done flag");

  // Only one kind of action can fire in a cell per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cls_hit, add_hit, rem_hit}))
    else $error("more than one cell action at once");

  // An add marks the slot valid, a remove clears it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_hit |=> rule_valid_q[$past(dir)])
    else $error("added rule not marked valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_hit |=> !rule_valid_q[$past(dir)])
    else $error("removed rule still marked valid");

endmodule

FILE: hw/rtl/five_tuple_packet_filter_rule_table.sv
// Top level of the five-tuple packet filter rule table: entry stage, cell chain, result buffer.
// Depends on ftf_pkg and ftf_cell.
//
// A request word (classify, add or remove) enters an entry register and then walks down a
// chain of RULES_PER_DIRECTION rule cells, one cell per cycle; each cell holds the outbound
// and the inbound rule of one slot, so the lowest matching or free slot acts first. The
// result goes from the last cell into the output register, or into the skid stage while
// the output waits. Only one word is in the chain at a time, so the block takes a new word
// only once the last one has left the chain and the skid stage is empty. A two-deep result
// buffer lets the next word enter while a result still waits on the output.
module five_tuple_packet_filter_rule_table #(
  parameter int RULES_PER_DIRECTION = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic        direction_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] src_mask_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] dst_ip_i,
  input  logic [31:0] dst_mask_i,
  input  logic [15:0] dst_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        verdict_o,
  output logic [1:0]  status_o
);

  ftf_pkg::ftf_word_t chain [RULES_PER_DIRECTION+1];
  logic [RULES_PER_DIRECTION:0] chain_valid;

  logic               entry_valid_q;
  ftf_pkg::ftf_body_t entry_body_q, entry_body_d;

  logic       chain_busy_q, chain_busy_d;
  logic       in_accept, arrival;
  logic       res_verdict;
  logic [1:0] res_status;

  logic       out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic       out_verdict_q, out_verdict_d, skid_verdict_q, skid_verdict_d;
  logic [1:0] out_status_q, out_status_d, skid_status_q, skid_status_d;

  assign in_ready_o = !chain_busy_q && !skid_valid_q;
  assign in_accept  = in_valid_i && in_ready_o;
  assign arrival    = chain[RULES_PER_DIRECTION].valid;

  // Build the entry word; words that need no table walk are settled here.
  always_comb begin
    entry_body_d.op                = operation_i;
    entry_body_d.dir               = direction_i;
    entry_body_d.rule.protocol     = protocol_i;
    entry_body_d.rule.src_addr     = src_ip_i;
    entry_body_d.rule.src_mask     = src_mask_i;
    entry_body_d.rule.src_port     = src_port_i;
    entry_body_d.rule.dst_addr     = dst_ip_i;
    entry_body_d.rule.dst_mask     = dst_mask_i;
    entry_body_d.rule.dst_port     = dst_port_i;
    entry_body_d.verdict           = 1'b0;
    unique case (operation_i)
      ftf_pkg::OP_CLASSIFY: entry_body_d.done = !((protocol_i == ftf_pkg::PROTO_TCP) ||
                                                  (protocol_i == ftf_pkg::PROTO_UDP));
      ftf_pkg::OP_ADD,
      ftf_pkg::OP_REMOVE:   entry_body_d.done = 1'b0;
      default:              entry_body_d.done = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else begin
      entry_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      entry_body_q <= entry_body_d;
    end
  end

  assign chain[0].valid = entry_valid_q;
  assign chain[0].body  = entry_body_q;

  // Chain of rule cells, lowest slot first.
  for (genvar g = 0; g < RULES_PER_DIRECTION; g++) begin : g_cell
    ftf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (chain[g]),
      .word_o (chain[g+1])
    );
  end

  for (genvar g = 0; g <= RULES_PER_DIRECTION; g++) begin : g_valid
    assign chain_valid[g] = chain[g].valid;
  end

  // Result of the word leaving the chain.
  always_comb begin
    res_verdict = chain[RULES_PER_DIRECTION].body.verdict;
    res_status  = ftf_pkg::STATUS_DONE;
    if (!chain[RULES_PER_DIRECTION].body.done) begin
      unique case (chain[RULES_PER_DIRECTION].body.op)
        ftf_pkg::OP_ADD:    res_status = ftf_pkg::STATUS_FULL;
        ftf_pkg::OP_REMOVE: res_status = ftf_pkg::STATUS_NOT_FOUND;
        default:            res_status = ftf_pkg::STATUS_DONE;
      endcase
    end
  end

  // Chain occupancy and the output register with its skid stage.
  always_comb begin
    chain_busy_d   = chain_busy_q;
    out_valid_d    = out_valid_q;
    out_verdict_d  = out_verdict_q;
    out_status_d   = out_status_q;
    skid_valid_d   = skid_valid_q;
    skid_verdict_d = skid_verdict_q;
    skid_status_d  = skid_status_q;

    if (in_accept) begin
      chain_busy_d = 1'b1;
    end else if (arrival) begin
      chain_busy_d = 1'b0;
    end

    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d   = 1'b1;
        out_verdict_d = skid_verdict_q;
        out_status_d  = skid_status_q;
        skid_valid_d  = 1'b0;
      end else begin
        out_valid_d   = arrival;
        out_verdict_d = res_verdict;
        out_status_d  = res_status;
      end
    end else if (arrival) begin
      skid_valid_d   = 1'b1;
      skid_verdict_d = res_verdict;
      skid_status_d  = res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_busy_q <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      chain_busy_q <= chain_busy_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_verdict_q  <= out_verdict_d;
    out_status_q   <= out_status_d;
    skid_verdict_q <= skid_verdict_d;
    skid_status_q  <= skid_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_verdict_q;
  assign status_o    = out_status_q;

  // At most one word walks the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_valid))
    else $error("more than one word in the cell chain");

  // A word only leaves the chain while the chain is marked busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    arrival |-> chain_busy_q)
    else $error("word left the chain while it was idle");

  // The skid stage only fills behind a waiting output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full with empty output register");

  // A word never arrives while the skid stage is still full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    arrival |-> !skid_valid_q)
    else $error("result arrived with skid stage full");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for five_tuple_packet_filter_rule_table.
// It predicts every verdict and status word from its own copy of both rule tables.
// Depends on ftf_pkg and the RTL of the block; needs no files and no arguments.
module testbench;

  localparam int RULES        = 16;
  localparam int TABLE_SLOTS  = 2 * RULES;
  localparam int RANDOM_WORDS = 1930;
  localparam int PHASE_WORDS  = 150;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = RULES + 4;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic       VERDICT_ACCEPT = 1'b0;
  localparam logic       VERDICT_DROP   = 1'b1;
  localparam logic       DIR_OUTBOUND   = 1'b0;
  localparam logic       DIR_INBOUND    = 1'b1;

  // One request word as the sender presents it.
  typedef struct packed {
    logic [1:0]         op;
    logic               dir;
    ftf_pkg::ftf_rule_t rule;
  } filter_req_t;

  // Predicts the outcome of each accepted request and checks the result words in order.
  class filter_scoreboard;
    bit                 slot_used [TABLE_SLOTS];
    ftf_pkg::ftf_rule_t slot_rule [TABLE_SLOTS];
    logic [2:0]         outcome_q [$];
    int                 mismatches;

    function bit addr_hit(logic [31:0] rule_addr, logic [31:0] rule_mask,
                          logic [31:0] pkt_addr);
      return (rule_addr == '0) || (((rule_addr ^ pkt_addr) & rule_mask) == '0);
    endfunction

    // A zero rule field is a wildcard; addresses compare under their own mask.
    function bit rule_hits(ftf_pkg::ftf_rule_t r, ftf_pkg::ftf_rule_t p);
      if (r.protocol != '0 && r.protocol != p.protocol) return 1'b0;
      if (!addr_hit(r.src_addr, r.src_mask, p.src_addr)) return 1'b0;
      if (r.src_port != '0 && r.src_port != p.src_port) return 1'b0;
      if (!addr_hit(r.dst_addr, r.dst_mask, p.dst_addr)) return 1'b0;
      if (r.dst_port != '0 && r.dst_port != p.dst_port) return 1'b0;
      return 1'b1;
    endfunction

    function void note_word(filter_req_t w);
      int         base;
      logic       verdict;
      logic [1:0] status;
      base    = w.dir * RULES;
      verdict = VERDICT_ACCEPT;
      status  = ftf_pkg::STATUS_DONE;
      case (w.op)
        ftf_pkg::OP_CLASSIFY: begin
          if (w.rule.protocol == ftf_pkg::PROTO_TCP ||
              w.rule.protocol == ftf_pkg::PROTO_UDP) begin
            for (int i = 0; i < RULES; i++) begin
              if (slot_used[base + i] && rule_hits(slot_rule[base + i], w.rule)) begin
                verdict = VERDICT_DROP;
                break;
              end
            end
          end
        end
        ftf_pkg::OP_ADD: begin
          status = ftf_pkg::STATUS_FULL;
          for (int i = 0; i < RULES; i++) begin
            if (!slot_used[base + i]) begin
              slot_used[base + i] = 1'b1;
              slot_rule[base + i] = w.rule;
              status = ftf_pkg::STATUS_DONE;
              break;
            end
          end
        end
        ftf_pkg::OP_REMOVE: begin
          status = ftf_pkg::STATUS_NOT_FOUND;
          for (int i = 0; i < RULES; i++) begin
            if (slot_used[base + i] && slot_rule[base + i] == w.rule) begin
              slot_used[base + i] = 1'b0;
              status = ftf_pkg::STATUS_DONE;
              break;
            end
          end
        end
        default: begin
        end
      endcase
      outcome_q.push_back({verdict, status});
    endfunction

    function void check_result(logic verdict, logic [1:0] status);
      logic [2:0] want;
      if (outcome_q.size() == 0) begin
        $display("%0t: result word with none outstanding: verdict %0b status %0d",
                 $time, verdict, status);
        mismatches++;
        return;
      end
      want = outcome_q.pop_front();
      if (verdict !== want[2]) begin
        $display("%0t: verdict expected %0b actual %0b", $time, want[2], verdict);
        mismatches++;
      end
      if (status !== want[1:0]) begin
        $display("%0t: status expected %0d actual %0d", $time, want[1:0], status);
        mismatches++;
      end
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic        direction_i;
  logic [7:0]  protocol_i;
  logic [31:0] src_ip_i;
  logic [31:0] src_mask_i;
  logic [15:0] src_port_i;
  logic [31:0] dst_ip_i;
  logic [31:0] dst_mask_i;
  logic [15:0] dst_port_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        verdict_o;
  logic [1:0]  status_o;

  filter_scoreboard sb;
  filter_req_t      cur_req;
  bit               no_gaps;
  int               ready_hold = 0;
  int               idle_cycles = 0;

  five_tuple_packet_filter_rule_table #(
    .RULES_PER_DIRECTION(RULES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .direction_i(direction_i),
    .protocol_i (protocol_i),
    .src_ip_i   (src_ip_i),
    .src_mask_i (src_mask_i),
    .src_port_i (src_port_i),
    .dst_ip_i   (dst_ip_i),
    .dst_mask_i (dst_mask_i),
    .dst_port_i (dst_port_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .verdict_o  (verdict_o),
    .status_o   (status_o)
  );

  // Free-running clock, period 10.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Gap lengths: mostly none or short, a few long, none at all in quiet phases.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  // The receiver stalls at random, changing ready at the falling edge.
  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
      ready_hold  = idle_len();
    end
  end

  // Accepted words are recorded and checked at the rising edge; the watchdog runs here too.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(cur_req);
      if (out_valid_o && out_ready_i) sb.check_result(verdict_o, status_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic ftf_pkg::ftf_rule_t mk_rule(logic [7:0] proto, logic [31:0] sa,
                                                 logic [31:0] sm, logic [15:0] sp,
                                                 logic [31:0] da, logic [31:0] dm,
                                                 logic [15:0] dp);
    ftf_pkg::ftf_rule_t r;
    r.protocol = proto;
    r.src_addr = sa;
    r.src_mask = sm;
    r.src_port = sp;
    r.dst_addr = da;
    r.dst_mask = dm;
    r.dst_port = dp;
    return r;
  endfunction

  function automatic filter_req_t mk_req(logic [1:0] op, logic dir, ftf_pkg::ftf_rule_t r);
    filter_req_t w;
    w.op   = op;
    w.dir  = dir;
    w.rule = r;
    return w;
  endfunction

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_mask();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return 32'hFFFF_FFFF << $urandom_range(0, 32);
    endcase
  endfunction

  function automatic logic [15:0] rand_port();
    case ($urandom_range(0, 7))
      0, 1: return '0;
      2: return '1;
      3: return 16'd80;
      4: return 16'd443;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_proto();
    case ($urandom_range(0, 5))
      0: return '0;
      1, 2: return ftf_pkg::PROTO_TCP;
      3, 4: return ftf_pkg::PROTO_UDP;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic ftf_pkg::ftf_rule_t rand_rule();
    return mk_rule(rand_proto(), rand_addr(), rand_mask(), rand_port(), rand_addr(),
                   rand_mask(), rand_port());
  endfunction

  // A packet built to hit the given rule, now and then spoiled in one field.
  function automatic ftf_pkg::ftf_rule_t packet_near(ftf_pkg::ftf_rule_t r);
    ftf_pkg::ftf_rule_t p;
    p.protocol = (r.protocol != '0) ? r.protocol :
                 ($urandom_range(0, 1) ? ftf_pkg::PROTO_TCP : ftf_pkg::PROTO_UDP);
    p.src_addr = r.src_addr ^ ($urandom & ~r.src_mask);
    p.src_mask = $urandom;
    p.src_port = (r.src_port != '0) ? r.src_port : 16'($urandom);
    p.dst_addr = r.dst_addr ^ ($urandom & ~r.dst_mask);
    p.dst_mask = $urandom;
    p.dst_port = (r.dst_port != '0) ? r.dst_port : 16'($urandom);
    case ($urandom_range(0, 7))
      0: p.src_addr ^= 32'h1 << $urandom_range(0, 31);
      1: p.dst_addr ^= 32'h1 << $urandom_range(0, 31);
      2: p.src_port ^= 16'h1 << $urandom_range(0, 15);
      3: p.dst_port ^= 16'h1 << $urandom_range(0, 15);
      4: p.protocol = (p.protocol == ftf_pkg::PROTO_TCP) ? ftf_pkg::PROTO_UDP :
                                                           ftf_pkg::PROTO_TCP;
      default: begin
      end
    endcase
    return p;
  endfunction

  // Index of a random valid slot of one direction, or -1 when that table is empty.
  function automatic int pick_slot(logic dir);
    int count;
    int k;
    count = 0;
    for (int i = 0; i < RULES; i++) count += sb.slot_used[dir * RULES + i];
    if (count == 0) return -1;
    k = $urandom_range(0, count - 1);
    for (int i = 0; i < RULES; i++) begin
      if (sb.slot_used[dir * RULES + i]) begin
        if (k == 0) return dir * RULES + i;
        k--;
      end
    end
    return -1;
  endfunction

  // Presents one word at a falling edge, holds it until accepted, then idles for a random gap, which may be empty.
  // Returns at a falling edge, after the monitor has recorded the word.
  task automatic send_word(filter_req_t w);
    int gap;
    cur_req     = w;
    operation_i = w.op;
    direction_i = w.dir;
    protocol_i  = w.rule.protocol;
    src_ip_i    = w.rule.src_addr;
    src_mask_i  = w.rule.src_mask;
    src_port_i  = w.rule.src_port;
    dst_ip_i    = w.rule.dst_addr;
    dst_mask_i  = w.rule.dst_mask;
    dst_port_i  = w.rule.dst_port;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Sender pause until every outstanding result word has come back.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Builds one random request, mostly well-formed against the current tables.
  function automatic filter_req_t rand_req(bit fill_phase);
    ftf_pkg::ftf_rule_t r;
    logic               dir;
    int                 pick;
    int                 s;
    int                 add_pct;
    int                 rem_pct;
    dir     = $urandom_range(0, 1);
    pick    = $urandom_range(0, 99);
    add_pct = fill_phase ? 55 : 15;
    rem_pct = fill_phase ? 15 : 45;
    s       = pick_slot(dir);
    if (pick < 4) begin
      return mk_req(OP_UNUSED, dir, mk_rule(8'($urandom), $urandom, $urandom,
                    16'($urandom), $urandom, $urandom, 16'($urandom)));
    end
    if (pick < 4 + add_pct) begin
      // Now and then store a copy of a rule that is already there.
      r = (s >= 0 && $urandom_range(0, 9) == 0) ? sb.slot_rule[s] : rand_rule();
      return mk_req(ftf_pkg::OP_ADD, dir, r);
    end
    if (pick < 4 + add_pct + rem_pct) begin
      if (s >= 0 && $urandom_range(0, 3) != 0) begin
        r = sb.slot_rule[s];
        if ($urandom_range(0, 4) == 0) r.src_mask ^= 32'h1 << $urandom_range(0, 31);
      end else begin
        r = rand_rule();
      end
      return mk_req(ftf_pkg::OP_REMOVE, dir, r);
    end
    if (s >= 0 && $urandom_range(0, 3) != 0) begin
      r = packet_near(sb.slot_rule[s]);
    end else begin
      r = mk_rule(($urandom_range(0, 4) != 0) ? rand_proto() : 8'($urandom), $urandom,
                  $urandom, 16'($urandom), $urandom, $urandom, 16'($urandom));
    end
    return mk_req(ftf_pkg::OP_CLASSIFY, dir, r);
  endfunction

  // Main sequence: reset, directed words, random words, drain, verdict.
  initial begin
    ftf_pkg::ftf_rule_t net10;
    ftf_pkg::ftf_rule_t ones;
    ftf_pkg::ftf_rule_t dst_net;
    sb          = new();
    no_gaps     = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cur_req     = '0;
    operation_i = ftf_pkg::OP_CLASSIFY;
    direction_i = DIR_OUTBOUND;
    protocol_i  = '0;
    src_ip_i    = '0;
    src_mask_i  = '0;
    src_port_i  = '0;
    dst_ip_i    = '0;
    dst_mask_i  = '0;
    dst_port_i  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    net10   = mk_rule(ftf_pkg::PROTO_TCP, 32'h0A00_0000, 32'hFF00_0000, '0, '0, '0, '0);
    ones    = mk_rule('1, '1, '1, '1, '1, '1, '1);
    dst_net = mk_rule('0, 32'h0A00_0000, 32'hFF00_0000, '0, 32'hC0A8_0000,
                      32'hFFFF_0000, 16'd443);

    // Empty table accepts everything.
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_OUTBOUND,
                     mk_rule(ftf_pkg::PROTO_TCP, 32'h0A01_0203, '0, 16'd1234, '0, '0,
                             16'd80)));
    send_word(mk_req(ftf_pkg::OP_ADD, DIR_OUTBOUND, net10));
    // Hit, other direction, non-TCP/UDP protocol, protocol mismatch; masks on classify ignored.
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_OUTBOUND,
                     mk_rule(ftf_pkg::PROTO_TCP, 32'h0A01_0203, '1, 16'd1234, '1, '1,
                             16'd80)));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_INBOUND,
                     mk_rule(ftf_pkg::PROTO_TCP, 32'h0A01_0203, '0, 16'd1234, '0, '0,
                             16'd80)));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_OUTBOUND,
                     mk_rule(8'd1, 32'h0A01_0203, '0, '0, '0, '0, '0)));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_OUTBOUND,
                     mk_rule(ftf_pkg::PROTO_UDP, 32'h0A01_0203, '0, '0, '0, '0, '0)));
    // All-ones rule: protocol 255 can never match a TCP or UDP packet.
    send_word(mk_req(ftf_pkg::OP_ADD, DIR_INBOUND, ones));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_INBOUND,
                     mk_rule(ftf_pkg::PROTO_UDP, '1, '1, '1, '1, '1, '1)));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_INBOUND, mk_rule('1, '1, '1, '1, '1, '1, '1)));
    send_word(mk_req(ftf_pkg::OP_REMOVE, DIR_INBOUND, ones));
    send_word(mk_req(ftf_pkg::OP_REMOVE, DIR_INBOUND, ones));
    // Duplicate add, then remove both copies one at a time.
    send_word(mk_req(ftf_pkg::OP_ADD, DIR_OUTBOUND, net10));
    send_word(mk_req(ftf_pkg::OP_REMOVE, DIR_OUTBOUND, net10));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_OUTBOUND,
                     mk_rule(ftf_pkg::PROTO_TCP, 32'h0AFF_FFFF, '0, '0, '0, '0, '0)));
    send_word(mk_req(ftf_pkg::OP_REMOVE, DIR_OUTBOUND, net10));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_OUTBOUND,
                     mk_rule(ftf_pkg::PROTO_TCP, 32'h0AFF_FFFF, '0, '0, '0, '0, '0)));
    // Destination compares under its own mask, not the source mask.
    send_word(mk_req(ftf_pkg::OP_ADD, DIR_INBOUND, dst_net));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_INBOUND,
                     mk_rule(ftf_pkg::PROTO_TCP, 32'h0A09_0909, '0, '0, 32'hC0A8_0707, '0,
                             16'd443)));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_INBOUND,
                     mk_rule(ftf_pkg::PROTO_TCP, 32'h0A09_0909, '0, '0, 32'hC0A9_0000, '0,
                             16'd443)));
    send_word(mk_req(ftf_pkg::OP_CLASSIFY, DIR_INBOUND,
                     mk_rule(ftf_pkg::PROTO_UDP, 32'h0B09_0909, '0, '0, 32'hC0A8_0707, '0,
                             16'd443)));
    // Unused operation code leaves the tables alone.
    send_word(mk_req(OP_UNUSED, DIR_INBOUND, mk_rule('1, '1, '1, '1, '1, '1, '1)));
    send_word(mk_req(ftf_pkg::OP_REMOVE, DIR_INBOUND, dst_net));

    drain_results();

    // Random words in phases that alternate between filling and draining the tables.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_WORDS == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) drain_results();
      send_word(rand_req(((n / PHASE_WORDS) % 2) == 0));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
